/* design/sa_lru_pkg.sv */
// Shared types, codes and constants for the set-associative LRU tag store.
package sa_lru_pkg;

	localparam int ADDRESS_BITS     = 48;
	localparam int LINE_OFFSET_BITS = 6;
	localparam int LINE_W           = ADDRESS_BITS - LINE_OFFSET_BITS;
	localparam int CORE_FIELD_W     = 3;

	localparam int DEF_NUM_SETS  = 64;
	localparam int DEF_NUM_WAYS  = 8;
	localparam int DEF_NUM_CORES = 8;

	// line address bits folded into the set remainder per cycle
	localparam int REDUCE_STEP = 6;

	localparam logic [1:0] OP_ACCESS = 2'd0;
	localparam logic [1:0] OP_FILL   = 2'd1;
	localparam logic [1:0] OP_INVAL  = 2'd2;

	typedef struct packed {
		logic [1:0]              opcode;
		logic [CORE_FIELD_W-1:0] core;
		logic [ADDRESS_BITS-1:0] byte_address;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic              evicted;
		logic [LINE_W-1:0] evicted_line;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_REDUCE,
		ST_READ,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

/* design/set_assoc_lru_tag_store_core.sv */
// Set-associative tag store with true LRU replacement, one private store per core.
//
// Request channel (req_valid / req_stall / req) carries opcode, core and byte
// address; response channel (rsp_valid / rsp_stall / rsp) returns one item per
// request: hit, evicted and the evicted line address.
// One item is worked on at a time. A row of the tag RAM holds all ways of one
// core's set; it is read once, scanned one way per cycle by a single tag
// comparator, then on a hit or a fill rewritten with updated ranks in the final cycle.
// When NUM_SETS is not a power of two, the set remainder is first reduced
// from the line address, REDUCE_STEP bits at a time. Items with an unused opcode
// or an out-of-range core go straight to the final state without reading the row.
// The way scan sets the rate. The response register holds a finished item
// while rsp_stall is high; the final cycle waits for that register to free up.
// After reset the block sweeps the tag RAM, one row a cycle, clearing the
// valid bits of all NUM_CORES * 2**ceil(log2(NUM_SETS)) rows (512 by default),
// with req_stall high throughout.
module set_assoc_lru_tag_store_core #(
	parameter int NUM_SETS  = sa_lru_pkg::DEF_NUM_SETS,
	parameter int NUM_WAYS  = sa_lru_pkg::DEF_NUM_WAYS,
	parameter int NUM_CORES = sa_lru_pkg::DEF_NUM_CORES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  sa_lru_pkg::req_t  req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output sa_lru_pkg::rsp_t  rsp
);

	localparam int LINE_W     = sa_lru_pkg::LINE_W;
	localparam int STEP       = sa_lru_pkg::REDUCE_STEP;
	localparam int SET_W      = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int CORE_W     = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
	localparam int WAY_W      = $clog2(NUM_WAYS);
	localparam int ROW_W      = CORE_W + SET_W;
	localparam int ROWS       = NUM_CORES * (2 ** SET_W);
	localparam int REDUCE_CYC = (LINE_W + STEP - 1) / STEP;
	localparam int RED_W      = REDUCE_CYC * STEP;
	localparam int RCNT_W     = $clog2(REDUCE_CYC + 1);
	localparam bit SETS_POW2  = ((NUM_SETS & (NUM_SETS - 1)) == 0);

	typedef struct packed {
		logic              valid;
		logic [LINE_W-1:0] line;
		logic [WAY_W-1:0]  rank;
	} entry_t;

	typedef entry_t [NUM_WAYS-1:0] row_t;

	sa_lru_pkg::state_t state_q, state_d;

	row_t tag_mem_q [ROWS];
	row_t rd_data_q;

	logic [ROW_W-1:0]  clr_q;
	logic [RCNT_W-1:0] red_cnt_q;
	logic [WAY_W-1:0]  way_q;
	logic              rsp_valid_q;
	sa_lru_pkg::rsp_t  rsp_q;

	logic [1:0]        op_q;
	logic [CORE_W-1:0] core_q;
	logic [LINE_W-1:0] line_q;
	logic              skip_q;
	logic [SET_W-1:0]  set_q;
	logic [RED_W-1:0]  red_q;

	logic              hit_found_q, free_found_q;
	logic [WAY_W-1:0]  hit_way_q, free_way_q, lru_way_q, lru_rank_q;

	logic [LINE_W-1:0] req_line;
	logic              req_skip;
	logic              accept;
	logic              out_free;
	logic [ROW_W-1:0]  row_addr;
	logic [SET_W-1:0]  rem_next;

	logic              rd_en, wr_en;
	logic [ROW_W-1:0]  wr_addr;
	row_t              wr_data;

	row_t              new_row;
	logic              do_write;
	sa_lru_pkg::rsp_t  result;

	assign req_line = req.byte_address[sa_lru_pkg::ADDRESS_BITS-1:sa_lru_pkg::LINE_OFFSET_BITS];
	assign req_skip = (int'(req.core) >= NUM_CORES) || !((req.opcode == sa_lru_pkg::OP_ACCESS)
		|| (req.opcode == sa_lru_pkg::OP_FILL) || (req.opcode == sa_lru_pkg::OP_INVAL));
	assign req_stall = (state_q != sa_lru_pkg::ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign row_addr  = {core_q, set_q};
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Fold STEP line bits, MSB first, into the running set remainder.
	always_comb begin
		logic [SET_W:0] acc;
		acc = {1'b0, set_q};
		for (int k = 0; k < STEP; k++) begin
			acc = {acc[SET_W-1:0], red_q[RED_W-1-k]};
			if (acc >= (SET_W+1)'(NUM_SETS))
				acc = acc - (SET_W+1)'(NUM_SETS);
		end
		rem_next = acc[SET_W-1:0];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sa_lru_pkg::ST_CLEAR: begin
				if (clr_q == ROW_W'(ROWS - 1))
					state_d = sa_lru_pkg::ST_IDLE;
			end
			sa_lru_pkg::ST_IDLE: begin
				if (accept) begin
					if (req_skip)
						state_d = sa_lru_pkg::ST_DONE;
					else if (SETS_POW2)
						state_d = sa_lru_pkg::ST_READ;
					else
						state_d = sa_lru_pkg::ST_REDUCE;
				end
			end
			sa_lru_pkg::ST_REDUCE: begin
				if (red_cnt_q == RCNT_W'(REDUCE_CYC - 1))
					state_d = sa_lru_pkg::ST_READ;
			end
			sa_lru_pkg::ST_READ: state_d = sa_lru_pkg::ST_SCAN;
			sa_lru_pkg::ST_SCAN: begin
				if (way_q == WAY_W'(NUM_WAYS - 1))
					state_d = sa_lru_pkg::ST_DONE;
			end
			sa_lru_pkg::ST_DONE: begin
				if (out_free)
					state_d = sa_lru_pkg::ST_IDLE;
			end
			default: state_d = sa_lru_pkg::ST_CLEAR;
		endcase
	end

	// Row update and response for the finished scan.
	always_comb begin
		logic             is_inval, is_fill;
		logic [WAY_W-1:0] tw;
		logic [WAY_W:0]   old_rank;
		is_inval = (op_q == sa_lru_pkg::OP_INVAL);
		is_fill  = (op_q == sa_lru_pkg::OP_FILL);
		if (hit_found_q)
			tw = hit_way_q;
		else if (free_found_q)
			tw = free_way_q;
		else
			tw = lru_way_q;
		old_rank = hit_found_q ? {1'b0, rd_data_q[hit_way_q].rank} : (WAY_W+1)'(NUM_WAYS);

		new_row = rd_data_q;
		for (int i = 0; i < NUM_WAYS; i++) begin
			if (hit_found_q && is_inval) begin
				if (WAY_W'(i) == tw)
					new_row[i].valid = 1'b0;
				else if (rd_data_q[i].valid && ({1'b0, rd_data_q[i].rank} > old_rank))
					new_row[i].rank = rd_data_q[i].rank - 1'b1;
			end else begin
				if (WAY_W'(i) == tw) begin
					new_row[i].rank = '0;
					if (!hit_found_q) begin
						new_row[i].valid = 1'b1;
						new_row[i].line  = line_q;
					end
				end else if (rd_data_q[i].valid && ({1'b0, rd_data_q[i].rank} < old_rank)) begin
					new_row[i].rank = rd_data_q[i].rank + 1'b1;
				end
			end
		end

		do_write = !skip_q && (hit_found_q || is_fill);
		result.hit     = !skip_q && hit_found_q;
		result.evicted = !skip_q && !hit_found_q && is_fill && !free_found_q;
		result.evicted_line = result.evicted ? rd_data_q[lru_way_q].line : '0;
	end

	always_comb begin
		rd_en   = (state_q == sa_lru_pkg::ST_READ);
		wr_en   = 1'b0;
		wr_addr = row_addr;
		wr_data = new_row;
		if (state_q == sa_lru_pkg::ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else if (state_q == sa_lru_pkg::ST_DONE) begin
			wr_en = out_free && do_write;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			tag_mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= tag_mem_q[row_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sa_lru_pkg::ST_CLEAR;
			clr_q       <= '0;
			red_cnt_q   <= '0;
			way_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == sa_lru_pkg::ST_CLEAR)
				clr_q <= clr_q + 1'b1;
			if (accept)
				red_cnt_q <= '0;
			else if (state_q == sa_lru_pkg::ST_REDUCE)
				red_cnt_q <= red_cnt_q + 1'b1;
			if (state_q == sa_lru_pkg::ST_READ)
				way_q <= '0;
			else if (state_q == sa_lru_pkg::ST_SCAN)
				way_q <= way_q + 1'b1;
			if (state_q == sa_lru_pkg::ST_DONE && out_free)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		entry_t ent;
		logic   first;
		ent   = rd_data_q[way_q];
		first = (way_q == '0);
		if (accept) begin
			op_q   <= req.opcode;
			core_q <= CORE_W'(req.core);
			line_q <= req_line;
			skip_q <= req_skip;
			red_q  <= RED_W'(req_line);
			set_q  <= SETS_POW2 ? (req_line[SET_W-1:0] & SET_W'(NUM_SETS - 1)) : '0;
		end
		if (state_q == sa_lru_pkg::ST_REDUCE) begin
			red_q <= red_q << STEP;
			set_q <= rem_next;
		end
		if (state_q == sa_lru_pkg::ST_SCAN) begin
			// first matching way and first free way win
			if (ent.valid && (ent.line == line_q) && (first || !hit_found_q)) begin
				hit_found_q <= 1'b1;
				hit_way_q   <= way_q;
			end else if (first) begin
				hit_found_q <= 1'b0;
			end
			if (!ent.valid && (first || !free_found_q)) begin
				free_found_q <= 1'b1;
				free_way_q   <= way_q;
			end else if (first) begin
				free_found_q <= 1'b0;
			end
			if (first || (ent.rank > lru_rank_q)) begin
				lru_way_q  <= way_q;
				lru_rank_q <= ent.rank;
			end
		end
		if (state_q == sa_lru_pkg::ST_DONE && out_free)
			rsp_q <= result;
	end

endmodule

/* verif/tb_set_assoc_lru_tag_store_core.sv */
// Testbench for the per-core set-associative LRU tag store: directed table, random items, checks.
module tb_set_assoc_lru_tag_store_core;

	localparam int NUM_SETS  = sa_lru_pkg::DEF_NUM_SETS;
	localparam int NUM_WAYS  = sa_lru_pkg::DEF_NUM_WAYS;
	localparam int NUM_CORES = sa_lru_pkg::DEF_NUM_CORES;
	localparam int SET_W     = $clog2(NUM_SETS);
	localparam int TAG_W     = sa_lru_pkg::LINE_W - SET_W;
	localparam int RAND_ITEMS = 700;
	localparam int DUE_DEPTH  = 1024;
	localparam int MAX_ROWS   = 32;

	// the package names no code for the spare opcode
	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef struct {
		sa_lru_pkg::req_t item;
		bit               typed;
		sa_lru_pkg::rsp_t want;
	} probe_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	sa_lru_pkg::req_t req_item = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	sa_lru_pkg::rsp_t rsp_item;

	// private copy of the tag store
	logic             line_vld  [NUM_CORES][NUM_SETS][NUM_WAYS];
	logic [TAG_W-1:0] line_tags [NUM_CORES][NUM_SETS][NUM_WAYS];
	logic [2:0]       line_rank [NUM_CORES][NUM_SETS][NUM_WAYS];

	// expected results in order, written at due_wr and read at due_rd
	sa_lru_pkg::rsp_t due_rsp [DUE_DEPTH];
	int due_wr = 0;
	int due_rd = 0;

	probe_row_t rows [MAX_ROWS];
	int n_rows = 0;

	int mismatches = 0;
	bit quiet = 1'b0;

	set_assoc_lru_tag_store_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#4000000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic flag_mismatch(string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic logic [sa_lru_pkg::ADDRESS_BITS-1:0] line_addr(logic [TAG_W-1:0] tg,
			logic [SET_W-1:0] s, logic [sa_lru_pkg::LINE_OFFSET_BITS-1:0] off);
		return {tg, s, off};
	endfunction

	// way w becomes most recent; valid ways more recent than its old rank age by one
	function automatic void make_mru(int c, int s, int w, int old_rank);
		int i;
		for (i = 0; i < NUM_WAYS; i++)
			if (line_vld[c][s][i] && i != w && int'(line_rank[c][s][i]) < old_rank)
				line_rank[c][s][i] = line_rank[c][s][i] + 3'd1;
		line_rank[c][s][w] = '0;
	endfunction

	function automatic sa_lru_pkg::rsp_t lru_lookup(sa_lru_pkg::req_t r);
		sa_lru_pkg::rsp_t o;
		logic [sa_lru_pkg::LINE_W-1:0] ln;
		logic [TAG_W-1:0] tg;
		int c, s, i, w, old;
		o = '0;
		ln = r.byte_address[sa_lru_pkg::ADDRESS_BITS-1:sa_lru_pkg::LINE_OFFSET_BITS];
		s = int'(ln[SET_W-1:0]);
		tg = ln[sa_lru_pkg::LINE_W-1:SET_W];
		c = int'(r.core);
		if (c >= NUM_CORES || r.opcode == OP_SPARE)
			return o;
		w = -1;
		for (i = 0; i < NUM_WAYS; i++)
			if (w < 0 && line_vld[c][s][i] && line_tags[c][s][i] == tg)
				w = i;
		if (w >= 0) begin
			o.hit = 1'b1;
			if (r.opcode == sa_lru_pkg::OP_INVAL) begin
				old = int'(line_rank[c][s][w]);
				line_vld[c][s][w] = 1'b0;
				for (i = 0; i < NUM_WAYS; i++)
					if (line_vld[c][s][i] && int'(line_rank[c][s][i]) > old)
						line_rank[c][s][i] = line_rank[c][s][i] - 3'd1;
			end else begin
				make_mru(c, s, w, int'(line_rank[c][s][w]));
			end
			return o;
		end
		if (r.opcode != sa_lru_pkg::OP_FILL)
			return o;
		for (i = 0; i < NUM_WAYS; i++)
			if (w < 0 && !line_vld[c][s][i])
				w = i;
		if (w < 0) begin
			w = 0;
			for (i = 1; i < NUM_WAYS; i++)
				if (line_rank[c][s][i] > line_rank[c][s][w])
					w = i;
			o.evicted = 1'b1;
			o.evicted_line = {line_tags[c][s][w], ln[SET_W-1:0]};
		end
		line_vld[c][s][w] = 1'b1;
		line_tags[c][s][w] = tg;
		make_mru(c, s, w, NUM_WAYS);
		return o;
	endfunction

	// called at a falling edge; returns at the falling edge after the item is taken
	task automatic send_req(sa_lru_pkg::req_t item, bit typed, sa_lru_pkg::rsp_t want);
		int gap;
		sa_lru_pkg::rsp_t pred;
		gap = quiet ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_item <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		pred = lru_lookup(item);
		due_rsp[due_wr % DUE_DEPTH] = typed ? want : pred;
		due_wr++;
		@(negedge clk);
	endtask

	function automatic probe_row_t row(logic [1:0] op, logic [2:0] core,
			logic [sa_lru_pkg::ADDRESS_BITS-1:0] addr, bit typed, sa_lru_pkg::rsp_t want);
		probe_row_t p;
		p.item.opcode = op;
		p.item.core = core;
		p.item.byte_address = addr;
		p.typed = typed;
		p.want = want;
		return p;
	endfunction

	function automatic void add_row(probe_row_t p);
		rows[n_rows] = p;
		n_rows++;
	endfunction

	// result side: random stall per item, compare in order
	initial begin
		int stall_left;
		sa_lru_pkg::rsp_t exp_rsp;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (rsp_valid === 1'b1 && !rsp_stall) begin
				if (due_wr == due_rd) begin
					flag_mismatch("result with nothing pending");
				end else begin
					exp_rsp = due_rsp[due_rd % DUE_DEPTH];
					due_rd++;
					if (rsp_item.hit !== exp_rsp.hit)
						flag_mismatch($sformatf("hit %b, want %b", rsp_item.hit, exp_rsp.hit));
					if (rsp_item.evicted !== exp_rsp.evicted)
						flag_mismatch($sformatf("evicted %b, want %b",
							rsp_item.evicted, exp_rsp.evicted));
					if (rsp_item.evicted_line !== exp_rsp.evicted_line)
						flag_mismatch($sformatf("evicted_line %h, want %h",
							rsp_item.evicted_line, exp_rsp.evicted_line));
				end
				stall_left = quiet ? 0 : $urandom_range(0, 8);
			end
			@(negedge clk);
			rsp_stall <= (stall_left > 0);
			if (rsp_valid === 1'b1 && stall_left > 0)
				stall_left--;
		end
	end

	initial begin
		logic [TAG_W-1:0] tag_pool[14];
		logic [SET_W-1:0] set_pool[3];
		logic [TAG_W-1:0] top_tag;
		logic [63:0] wide;
		sa_lru_pkg::rsp_t none, hit_only, evict_top;
		sa_lru_pkg::req_t r;
		int i, k, pick;

		for (i = 0; i < NUM_CORES; i++)
			for (k = 0; k < NUM_SETS; k++)
				for (pick = 0; pick < NUM_WAYS; pick++) begin
					line_vld[i][k][pick] = 1'b0;
					line_tags[i][k][pick] = '0;
					line_rank[i][k][pick] = '0;
				end

		top_tag = '1;
		none = '0;
		hit_only = '0;
		hit_only.hit = 1'b1;
		evict_top = '0;
		evict_top.evicted = 1'b1;
		evict_top.evicted_line = '1;

		add_row(row(sa_lru_pkg::OP_ACCESS, 3'd0, '0, 1, none));
		add_row(row(sa_lru_pkg::OP_INVAL, 3'd7, '1, 1, none));
		add_row(row(OP_SPARE, 3'd7, '1, 1, none));
		add_row(row(sa_lru_pkg::OP_FILL, 3'd7, '1, 1, none));
		add_row(row(sa_lru_pkg::OP_ACCESS, 3'd7, line_addr(top_tag, '1, '0), 1, hit_only));
		// refill of a resident line acts as an access
		add_row(row(sa_lru_pkg::OP_FILL, 3'd7, '1, 1, hit_only));
		for (i = 0; i < 7; i++)
			add_row(row(sa_lru_pkg::OP_FILL, 3'd7,
				line_addr(TAG_W'(i), '1, 6'($urandom)), 0, none));
		// set now full, top line is least recent
		add_row(row(sa_lru_pkg::OP_FILL, 3'd7, line_addr(TAG_W'(7), '1, '0), 1, evict_top));
		add_row(row(sa_lru_pkg::OP_INVAL, 3'd7, line_addr(TAG_W'(3), '1, 6'd17), 0, none));
		add_row(row(sa_lru_pkg::OP_INVAL, 3'd7, line_addr(TAG_W'(3), '1, 6'd40), 0, none));
		add_row(row(sa_lru_pkg::OP_FILL, 3'd7, line_addr(TAG_W'(8), '1, '1), 0, none));
		add_row(row(sa_lru_pkg::OP_ACCESS, 3'd7, line_addr(TAG_W'(3), '1, '0), 0, none));
		add_row(row(sa_lru_pkg::OP_ACCESS, 3'd6, '1, 1, none));
		add_row(row(OP_SPARE, 3'd0, '0, 1, none));
		add_row(row(sa_lru_pkg::OP_FILL, 3'd0, '0, 0, none));
		add_row(row(sa_lru_pkg::OP_ACCESS, 3'd0, 48'd63, 0, none));
		add_row(row(sa_lru_pkg::OP_INVAL, 3'd0, '0, 0, none));

		tag_pool[0] = '0;
		tag_pool[1] = '1;
		for (i = 2; i < 14; i++) begin
			wide = {$urandom, $urandom};
			tag_pool[i] = wide[TAG_W-1:0];
		end
		set_pool[0] = '0;
		set_pool[1] = '1;
		set_pool[2] = SET_W'($urandom_range(1, NUM_SETS - 2));

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (i = 0; i < n_rows; i++)
			send_req(rows[i].item, rows[i].typed, rows[i].want);

		for (i = 0; i < RAND_ITEMS; i++) begin
			if (i % 175 == 0) begin
				// let the block drain completely
				req_valid <= 1'b0;
				while (due_wr != due_rd) @(posedge clk);
				@(negedge clk);
			end
			quiet = ((i / 40) % 4 == 1);
			pick = $urandom_range(0, 99);
			if (pick < 38)
				r.opcode = sa_lru_pkg::OP_FILL;
			else if (pick < 73)
				r.opcode = sa_lru_pkg::OP_ACCESS;
			else if (pick < 95)
				r.opcode = sa_lru_pkg::OP_INVAL;
			else
				r.opcode = OP_SPARE;
			r.core = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
				: 3'($urandom_range(0, 1));
			if ($urandom_range(0, 6) == 0) begin
				wide = {$urandom, $urandom};
				r.byte_address = wide[sa_lru_pkg::ADDRESS_BITS-1:0];
			end else begin
				r.byte_address = line_addr(tag_pool[$urandom_range(0, 13)],
					set_pool[$urandom_range(0, 2)], 6'($urandom_range(0, 63)));
			end
			send_req(r, 0, none);
		end
		req_valid <= 1'b0;
		quiet = 1'b0;

		while (due_wr != due_rd) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && due_wr == due_rd)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* files.f */
design/sa_lru_pkg.sv
design/set_assoc_lru_tag_store_core.sv
verif/tb_set_assoc_lru_tag_store_core.sv
